FILE: hdl/mke_pkg.sv
package mke_pkg;

  // Config register map
  localparam int unsigned AddrWidth    = 2;
  localparam int unsigned DataWidth    = 32;
  localparam logic [AddrWidth-1:0] RegDotSamples = 2'd0;
  localparam logic [15:0] DotSamplesReset = 16'd2646;

  // ROM entry layout: count in [8:6] (0 means 8), dot/dash bits in [5:0]
  localparam int unsigned EntryWidth = 9;
  localparam logic [7:0]  CharBlank  = 8'h20;
  localparam logic [3:0]  GapsBlank  = 4'd2;
  localparam logic [3:0]  GapsEnd    = 4'd3;
  localparam logic [3:0]  CountFull  = 4'd8;

  // Sequencer steps
  localparam logic [2:0] StepIdle  = 3'd0;
  localparam logic [2:0] StepGap   = 3'd1;
  localparam logic [2:0] StepSpace = 3'd2;
  localparam logic [2:0] StepElem  = 3'd3;
  localparam logic [2:0] StepEnd   = 3'd4;

  // Branch conditions
  typedef enum logic [1:0] {
    CondNone  = 2'd0,  // go to nxt once the word is emitted
    CondStart = 2'd1,  // wait for an input word, gap -> tgt, else nxt
    CondCnt1  = 2'd2   // counter at one -> tgt, else nxt
  } cond_e;

  typedef struct packed {
    logic       emit;       // produce one segment
    logic       key;        // tone on
    logic       dash;       // length taken from the element bit
    logic       step_cnt;   // count down and shift the element bits
    logic       last_cnt1;  // flag last when the counter is at one
    logic       last_all;   // always flag last
    cond_e      cond;
    logic [2:0] nxt;
    logic [2:0] tgt;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input logic [2:0] step);
    uword_t w;
    w = '{emit: 1'b0, key: 1'b0, dash: 1'b0, step_cnt: 1'b0, last_cnt1: 1'b0,
          last_all: 1'b0, cond: CondNone, nxt: StepIdle, tgt: StepIdle};
    case (step)
      StepIdle: begin
        w.cond = CondStart;
        w.nxt  = StepSpace;
        w.tgt  = StepGap;
      end
      StepGap: begin
        w.emit      = 1'b1;
        w.step_cnt  = 1'b1;
        w.last_cnt1 = 1'b1;
        w.cond      = CondCnt1;
        w.nxt       = StepGap;
        w.tgt       = StepIdle;
      end
      StepSpace: begin
        w.emit = 1'b1;
        w.nxt  = StepElem;
      end
      StepElem: begin
        w.emit     = 1'b1;
        w.key      = 1'b1;
        w.dash     = 1'b1;
        w.step_cnt = 1'b1;
        w.cond     = CondCnt1;
        w.nxt      = StepSpace;
        w.tgt      = StepEnd;
      end
      StepEnd: begin
        w.emit     = 1'b1;
        w.last_all = 1'b1;
        w.nxt      = StepIdle;
      end
      default: begin
        w.nxt = StepIdle;
      end
    endcase
    return w;
  endfunction

  // Character code table, indexed by the low seven bits
  localparam logic [EntryWidth-1:0] KeyRom [128] = '{
    9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o000, 9'o000, 9'o412, 9'o000, 9'o000, 9'o412, 9'o000, 9'o000,
    9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o000, 9'o665, 9'o622, 9'o000, 9'o000, 9'o000, 9'o502, 9'o636,
    9'o515, 9'o000, 9'o000, 9'o512, 9'o663, 9'o000, 9'o652, 9'o511,
    9'o537, 9'o536, 9'o534, 9'o530, 9'o520, 9'o500, 9'o501, 9'o503,
    9'o507, 9'o517, 9'o607, 9'o625, 9'o000, 9'o521, 9'o000, 9'o614,
    9'o000, 9'o202, 9'o401, 9'o405, 9'o301, 9'o100, 9'o404, 9'o303,
    9'o400, 9'o200, 9'o416, 9'o305, 9'o402, 9'o203, 9'o201, 9'o307,
    9'o406, 9'o413, 9'o302, 9'o300, 9'o101, 9'o304, 9'o410, 9'o306,
    9'o411, 9'o415, 9'o403, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o000, 9'o202, 9'o401, 9'o405, 9'o301, 9'o100, 9'o404, 9'o303,
    9'o400, 9'o200, 9'o416, 9'o305, 9'o402, 9'o203, 9'o201, 9'o307,
    9'o406, 9'o413, 9'o302, 9'o300, 9'o101, 9'o304, 9'o410, 9'o306,
    9'o411, 9'o415, 9'o403, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000
  };

endpackage

FILE: hdl/mke_in_if.sv
interface mke_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] character;

  modport source (output valid, output action, output character, input ready);
  modport sink (input valid, input action, input character, output ready);
endinterface

FILE: hdl/mke_out_if.sv
interface mke_out_if;
  logic        valid;
  logic        ready;
  logic        key_on;
  logic [17:0] length_samples;
  logic        last;

  modport source (output valid, output key_on, output length_samples, output last,
                  input ready);
  modport sink (input valid, input key_on, input length_samples, input last,
                output ready);
endinterface

FILE: hdl/mke_seq.sv
module mke_seq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] unit_i,
  mke_in_if.sink      in_word,
  mke_out_if.source   out_word
);

  logic [2:0]  step_q, step_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [5:0]  bits_q, bits_d;
  logic        vld_q, vld_d;
  logic        key_q;
  logic [17:0] len_q;
  logic        last_q;

  mke_pkg::uword_t uw;
  logic [mke_pkg::EntryWidth-1:0] entry;
  logic        acc, gap, go, cnt_one, out_free, load;
  logic [17:0] len1, len3;

  assign uw       = mke_pkg::ucode(step_q);
  assign acc      = in_word.valid && in_word.ready;
  assign gap      = in_word.action || (in_word.character == mke_pkg::CharBlank);
  assign entry    = mke_pkg::KeyRom[in_word.character[6:0]];
  assign cnt_one  = (cnt_q == 4'd1);
  assign out_free = !vld_q || out_word.ready;
  assign go       = uw.emit ? out_free : 1'b1;
  assign load     = uw.emit && out_free;

  // Dot and dash lengths
  assign len1 = {2'b00, unit_i};
  assign len3 = {2'b00, unit_i} + {1'b0, unit_i, 1'b0};

  assign in_word.ready = (uw.cond == mke_pkg::CondStart);

  // Step sequencing and element counter
  always_comb begin
    step_d = step_q;
    cnt_d  = cnt_q;
    bits_d = bits_q;
    case (uw.cond)
      mke_pkg::CondStart: begin
        if (acc) begin
          if (gap) begin
            cnt_d  = in_word.action ? mke_pkg::GapsEnd : mke_pkg::GapsBlank;
            bits_d = '0;
            step_d = uw.tgt;
          end else begin
            cnt_d  = (entry[8:6] == 3'd0) ? mke_pkg::CountFull : {1'b0, entry[8:6]};
            bits_d = entry[5:0];
            step_d = uw.nxt;
          end
        end
      end
      mke_pkg::CondCnt1: begin
        if (go) step_d = cnt_one ? uw.tgt : uw.nxt;
      end
      default: begin
        if (go) step_d = uw.nxt;
      end
    endcase
    if (go && uw.step_cnt) begin
      cnt_d  = cnt_q - 4'd1;
      bits_d = bits_q >> 1;
    end
  end

  // Output register valid
  always_comb begin
    if (load) vld_d = 1'b1;
    else if (out_word.ready) vld_d = 1'b0;
    else vld_d = vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mke_pkg::StepIdle;
      cnt_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
      vld_q  <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    if (load) begin
      key_q  <= uw.key;
      len_q  <= (uw.dash && bits_q[0]) ? len3 : len1;
      last_q <= uw.last_all || (uw.last_cnt1 && cnt_one);
    end
  end

  assign out_word.valid          = vld_q;
  assign out_word.key_on         = key_q;
  assign out_word.length_samples = len_q;
  assign out_word.last           = last_q;

endmodule

FILE: hdl/morse_keying_encoder_core.sv
// Morse keying encoder.
// in_word carries one character (action 0) or an end-of-text marker (action 1).
// out_word carries keying segments: key_on, length_samples in samples, and last
// on the final segment of each input word.
// A character gives a silence/tone pair per element and a closing silence; a
// blank gives two silences and end of text three. dot_samples (APB, offset 0)
// sets the unit; zero counts as one sample. Write it only while idle.
// Timing: in_word.ready is high while the sequencer waits. The first segment
// is registered from the step after the wait step, then one segment per cycle
// unless the output stalls. A character runs the wait step, a space and an
// element step per element and a closing end step; a blank or end of text
// runs the wait step and one gap step per silence. The last segment may still
// sit in the output register when the next input word is taken. A full output
// register and the sequencer hold while out_word.ready is low; nothing is dropped.
// Reset clears the sequencer and the output valid and loads dot_samples = 2646.
module morse_keying_encoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mke_pkg::AddrWidth-1:0] paddr,
  input  logic [mke_pkg::DataWidth-1:0] pwdata,
  output logic [mke_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  mke_in_if.sink                        in_word,
  mke_out_if.source                     out_word
);

  logic [15:0] dot_q, dot_d;
  logic [15:0] unit;
  logic        wr_en;

  // Register write
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == mke_pkg::RegDotSamples);

  always_comb begin
    dot_d = dot_q;
    if (wr_en) dot_d = pwdata[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dot_q <= mke_pkg::DotSamplesReset;
    else dot_q <= dot_d;
  end

  // Register read
  always_comb begin
    prdata = '0;
    if (paddr == mke_pkg::RegDotSamples) prdata = {16'h0000, dot_q};
  end

  // Zero unit means one sample
  assign unit = (dot_q == 16'd0) ? 16'd1 : dot_q;

  mke_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .unit_i   (unit),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
